FILE: rtl/gtm_pkg.sv
// gtm_pkg: shared constants, register codes, state and command types
// of the goertzel tone magnitude unit; used by every rtl file
`timescale 1ns / 1ps

package gtm_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int MAX_BLOCK       = 255;

   localparam int LEN_W  = 8;
   localparam int CMP_W  = (MAX_BLOCK > 255) ? $clog2(MAX_BLOCK + 1) : LEN_W;

   localparam int STATE_W   = 40;
   localparam int COEF_W    = 16;
   localparam int MAG_W     = 16;
   localparam int CHUNK_W   = 22;
   localparam int OPA_W     = 2 * CHUNK_W;
   localparam int MUL_A_W   = CHUNK_W + 1;
   localparam int MUL_B_W   = COEF_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + CHUNK_W;
   localparam int Q14_SHIFT = 14;
   localparam int Q16_SHIFT = 16;
   localparam int TERM_W    = STATE_W + COEF_W - Q14_SHIFT + 2;
   localparam int SCALED_W  = ACC_W - Q16_SHIFT;
   localparam int RAD_W     = 2 * MAG_W + 2;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int ROUND_Q14 = 1 << (Q14_SHIFT - 1);
   localparam int ROUND_Q16 = 1 << (Q16_SHIFT - 1);
   localparam int MAG_MAX   = (1 << MAG_W) - 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECURSION_COEFF  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COSINE_TERM      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SINE_TERM        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_RECIPROCAL = 3'd4;

   localparam logic [LEN_W-1:0]  RST_BLOCK_LENGTH     = 8'd80;
   localparam logic [COEF_W-1:0] RST_RECURSION_COEFF  = 16'd23170;
   localparam logic [COEF_W-1:0] RST_COSINE_TERM      = 16'd11585;
   localparam logic [COEF_W-1:0] RST_SINE_TERM        = 16'd11585;
   localparam logic [COEF_W-1:0] RST_SCALE_RECIPROCAL = 16'd1638;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_ACC,
      ST_STORE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQ_SUM,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_OUTPUT
   } state_type;

   typedef enum logic [2:0] {
      OP_REC,
      OP_COS,
      OP_SIN,
      OP_RE,
      OP_IM
   } op_type;

   typedef enum logic [1:0] {
      MSEL_LO,
      MSEL_HI,
      MSEL_SQ_RE,
      MSEL_SQ_IM
   } msel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_HI,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      RND_NONE,
      RND_Q14,
      RND_Q16
   } rnd_type;

   typedef struct packed {
      op_type     op;
      msel_type   msel;
      acc_op_type acc_op;
      rnd_type    rnd;
      logic       take_sample;
      logic       store;
      logic       root_start;
      logic       out_load;
      logic       clr_state;
   } cmd_type;

   typedef struct packed {
      logic blk_end;
      logic root_done;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/gtm_isqrt.sv
// gtm_isqrt: iterative integer square root, one result bit per cycle
// depends on gtm_pkg for default widths
`timescale 1ns / 1ps

module gtm_isqrt #(
   parameter int RAD_W = gtm_pkg::RAD_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_W-1:0]     radicand,
   output logic                 done,
   output logic [RAD_W/2-1:0]   root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int CNT_W  = $clog2(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: rtl/gtm_datapath.sv
// gtm_datapath: config registers, recursion state, shared multiplier,
// accumulator, magnitude path and result register; uses gtm_pkg, gtm_isqrt
`timescale 1ns / 1ps

module gtm_datapath #(
   parameter int SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [gtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gtm_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   input  gtm_pkg::cmd_type                cmd,
   output gtm_pkg::status_type             status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [gtm_pkg::MAG_W-1:0]       rsp_magnitude,
   output logic                            rsp_saturated
);

   localparam int STATE_W  = gtm_pkg::STATE_W;
   localparam int COEF_W   = gtm_pkg::COEF_W;
   localparam int MAG_W    = gtm_pkg::MAG_W;
   localparam int CHUNK_W  = gtm_pkg::CHUNK_W;
   localparam int OPA_W    = gtm_pkg::OPA_W;
   localparam int MUL_A_W  = gtm_pkg::MUL_A_W;
   localparam int MUL_B_W  = gtm_pkg::MUL_B_W;
   localparam int PROD_W   = gtm_pkg::PROD_W;
   localparam int ACC_W    = gtm_pkg::ACC_W;
   localparam int Q14      = gtm_pkg::Q14_SHIFT;
   localparam int Q16      = gtm_pkg::Q16_SHIFT;
   localparam int TERM_W   = gtm_pkg::TERM_W;
   localparam int SCALED_W = gtm_pkg::SCALED_W;
   localparam int LEN_W    = gtm_pkg::LEN_W;
   localparam int CMP_W    = gtm_pkg::CMP_W;
   localparam int RAD_W    = gtm_pkg::RAD_W;
   localparam int ROOT_W   = gtm_pkg::ROOT_W;

   // configuration
   logic [LEN_W-1:0]         blen_ff;
   logic signed [COEF_W-1:0] coeff_ff, cos_ff, sin_ff;
   logic [COEF_W-1:0]        scale_ff;

   // recursion state
   logic signed [STATE_W-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [LEN_W-1:0]          cnt_ff, cnt_in, cnt_next;
   logic [SAMPLE_BITS-1:0]    sample_ff;

   // arithmetic
   logic signed [OPA_W-1:0]   opa;
   logic signed [MUL_B_W-1:0] opb;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]   acc_in, acc_ff, rnd_val;
   logic [STATE_W-1:0]        q0;
   logic signed [TERM_W-1:0]  term;
   logic signed [SCALED_W-1:0] scaled, scaled_neg;
   logic                      ovf;
   logic [MAG_W-1:0]          mag_abs;

   logic signed [OPA_W-1:0] re_ff, re_in, im_ff, im_in;
   logic [MAG_W-1:0]        are_ff, are_in, aim_ff, aim_in;
   logic                    sat_ff, sat_in;

   // block length
   logic [CMP_W-1:0] len_eff;
   logic             blk_end;

   // root and result
   logic [ROOT_W-1:0] root;
   logic              root_done;
   logic              sat_all;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]  rsp_mag_ff;
   logic              rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff  <= gtm_pkg::RST_BLOCK_LENGTH;
         coeff_ff <= gtm_pkg::RST_RECURSION_COEFF;
         cos_ff   <= gtm_pkg::RST_COSINE_TERM;
         sin_ff   <= gtm_pkg::RST_SINE_TERM;
         scale_ff <= gtm_pkg::RST_SCALE_RECIPROCAL;
      end else if (csr_valid) begin
         case (csr_index)
            gtm_pkg::CSR_BLOCK_LENGTH:     blen_ff  <= csr_data[LEN_W-1:0];
            gtm_pkg::CSR_RECURSION_COEFF:  coeff_ff <= csr_data;
            gtm_pkg::CSR_COSINE_TERM:      cos_ff   <= csr_data;
            gtm_pkg::CSR_SINE_TERM:        sin_ff   <= csr_data;
            gtm_pkg::CSR_SCALE_RECIPROCAL: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective block length and end of block
   always_comb begin
      len_eff = CMP_W'(blen_ff);
      if (len_eff == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_eff > CMP_W'(gtm_pkg::MAX_BLOCK)) begin
         len_eff = CMP_W'(gtm_pkg::MAX_BLOCK);
      end
      cnt_next = cnt_ff + 1'b1;
      blk_end  = (CMP_W'(cnt_next) >= len_eff) || (cnt_next == '0);
   end

   // operand select and shared multiplier
   always_comb begin
      case (cmd.op)
         gtm_pkg::OP_REC: begin
            opa = OPA_W'(q1_ff);
            opb = MUL_B_W'(coeff_ff);
         end
         gtm_pkg::OP_COS: begin
            opa = OPA_W'(q2_ff);
            opb = MUL_B_W'(cos_ff);
         end
         gtm_pkg::OP_SIN: begin
            opa = OPA_W'(q2_ff);
            opb = MUL_B_W'(sin_ff);
         end
         gtm_pkg::OP_RE: begin
            opa = re_ff;
            opb = $signed({1'b0, scale_ff});
         end
         gtm_pkg::OP_IM: begin
            opa = im_ff;
            opb = $signed({1'b0, scale_ff});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      case (cmd.msel)
         gtm_pkg::MSEL_LO: begin
            mul_a = $signed({1'b0, opa[CHUNK_W-1:0]});
            mul_b = opb;
         end
         gtm_pkg::MSEL_HI: begin
            mul_a = MUL_A_W'($signed(opa[OPA_W-1:CHUNK_W]));
            mul_b = opb;
         end
         gtm_pkg::MSEL_SQ_RE: begin
            mul_a = $signed({{(MUL_A_W - MAG_W){1'b0}}, are_ff});
            mul_b = $signed({1'b0, are_ff});
         end
         gtm_pkg::MSEL_SQ_IM: begin
            mul_a = $signed({{(MUL_A_W - MAG_W){1'b0}}, aim_ff});
            mul_b = $signed({1'b0, aim_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // accumulator
   always_comb begin
      case (cmd.rnd)
         gtm_pkg::RND_Q14: rnd_val = ACC_W'(gtm_pkg::ROUND_Q14);
         gtm_pkg::RND_Q16: rnd_val = ACC_W'(gtm_pkg::ROUND_Q16);
         default:          rnd_val = '0;
      endcase
      case (cmd.acc_op)
         gtm_pkg::ACC_LOAD:   acc_in = ACC_W'(prod_ff) + rnd_val;
         gtm_pkg::ACC_ADD_HI: acc_in = acc_ff + (ACC_W'(prod_ff) <<< CHUNK_W);
         gtm_pkg::ACC_ADD:    acc_in = acc_ff + ACC_W'(prod_ff);
         default:             acc_in = acc_ff;
      endcase
   end

   // stores at the end of each product
   always_comb begin
      q0         = acc_ff[Q14+STATE_W-1:Q14] - q2_ff + STATE_W'(sample_ff);
      term       = $signed(acc_ff[Q14+TERM_W-1:Q14]);
      scaled     = $signed(acc_ff[ACC_W-1:Q16]);
      scaled_neg = -scaled;
      ovf        = (scaled > SCALED_W'(gtm_pkg::MAG_MAX)) ||
                   (scaled < SCALED_W'(-gtm_pkg::MAG_MAX));
      mag_abs    = scaled[SCALED_W-1] ? scaled_neg[MAG_W-1:0] : scaled[MAG_W-1:0];

      q1_in  = q1_ff;
      q2_in  = q2_ff;
      cnt_in = cnt_ff;
      re_in  = re_ff;
      im_in  = im_ff;
      are_in = are_ff;
      aim_in = aim_ff;
      sat_in = sat_ff;
      if (cmd.clr_state) begin
         q1_in  = '0;
         q2_in  = '0;
         cnt_in = '0;
      end else if (cmd.store) begin
         case (cmd.op)
            gtm_pkg::OP_REC: begin
               q1_in  = $signed(q0);
               q2_in  = q1_ff;
               cnt_in = cnt_next;
            end
            gtm_pkg::OP_COS: re_in = OPA_W'(q1_ff) - OPA_W'(term);
            gtm_pkg::OP_SIN: im_in = OPA_W'(term);
            gtm_pkg::OP_RE: begin
               are_in = mag_abs;
               sat_in = ovf;
            end
            gtm_pkg::OP_IM: begin
               aim_in = mag_abs;
               sat_in = sat_ff | ovf;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ff  <= '0;
         q2_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         q1_ff  <= q1_in;
         q2_ff  <= q2_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         sample_ff <= req_sample;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      re_ff   <= re_in;
      im_ff   <= im_in;
      are_ff  <= are_in;
      aim_ff  <= aim_in;
      sat_ff  <= sat_in;
   end

   gtm_isqrt #(
      .RAD_W (RAD_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (acc_ff[RAD_W-1:0]),
      .done     (root_done),
      .root     (root)
   );

   // result register
   assign sat_all = sat_ff | root[ROOT_W-1];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_mag_ff <= sat_all ? {MAG_W{1'b1}} : root[MAG_W-1:0];
         rsp_sat_ff <= sat_all;
      end
   end

   assign status.blk_end   = blk_end;
   assign status.root_done = root_done;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

FILE: rtl/gtm_ctrl.sv
// gtm_ctrl: sequencer for the recursion and the end-of-block magnitude
// steps; drives gtm_datapath commands, uses gtm_pkg types
`timescale 1ns / 1ps

module gtm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gtm_pkg::status_type status,
   output gtm_pkg::cmd_type    cmd
);

   gtm_pkg::state_type state_ff, state_in;
   gtm_pkg::op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtm_pkg::ST_IDLE;
         op_ff    <= gtm_pkg::OP_REC;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      req_ready       = 1'b0;
      cmd.op          = op_ff;
      cmd.msel        = gtm_pkg::MSEL_LO;
      cmd.acc_op      = gtm_pkg::ACC_HOLD;
      cmd.rnd         = gtm_pkg::RND_NONE;
      cmd.take_sample = 1'b0;
      cmd.store       = 1'b0;
      cmd.root_start  = 1'b0;
      cmd.out_load    = 1'b0;
      cmd.clr_state   = 1'b0;
      case (state_ff)
         gtm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_sample = 1'b1;
               op_in           = gtm_pkg::OP_REC;
               state_in        = gtm_pkg::ST_MUL_LO;
            end
         end
         gtm_pkg::ST_MUL_LO: begin
            cmd.msel = gtm_pkg::MSEL_LO;
            state_in = gtm_pkg::ST_MUL_HI;
         end
         gtm_pkg::ST_MUL_HI: begin
            cmd.msel   = gtm_pkg::MSEL_HI;
            cmd.acc_op = gtm_pkg::ACC_LOAD;
            if (op_ff == gtm_pkg::OP_RE || op_ff == gtm_pkg::OP_IM) begin
               cmd.rnd = gtm_pkg::RND_Q16;
            end else begin
               cmd.rnd = gtm_pkg::RND_Q14;
            end
            state_in = gtm_pkg::ST_MUL_ACC;
         end
         gtm_pkg::ST_MUL_ACC: begin
            cmd.acc_op = gtm_pkg::ACC_ADD_HI;
            state_in   = gtm_pkg::ST_STORE;
         end
         gtm_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            case (op_ff)
               gtm_pkg::OP_REC: begin
                  if (status.blk_end) begin
                     op_in    = gtm_pkg::OP_COS;
                     state_in = gtm_pkg::ST_MUL_LO;
                  end else begin
                     state_in = gtm_pkg::ST_IDLE;
                  end
               end
               gtm_pkg::OP_COS: begin
                  op_in    = gtm_pkg::OP_SIN;
                  state_in = gtm_pkg::ST_MUL_LO;
               end
               gtm_pkg::OP_SIN: begin
                  op_in    = gtm_pkg::OP_RE;
                  state_in = gtm_pkg::ST_MUL_LO;
               end
               gtm_pkg::OP_RE: begin
                  op_in    = gtm_pkg::OP_IM;
                  state_in = gtm_pkg::ST_MUL_LO;
               end
               gtm_pkg::OP_IM: begin
                  state_in = gtm_pkg::ST_SQ_A;
               end
               default: state_in = gtm_pkg::ST_IDLE;
            endcase
         end
         gtm_pkg::ST_SQ_A: begin
            cmd.msel = gtm_pkg::MSEL_SQ_RE;
            state_in = gtm_pkg::ST_SQ_B;
         end
         gtm_pkg::ST_SQ_B: begin
            cmd.msel   = gtm_pkg::MSEL_SQ_IM;
            cmd.acc_op = gtm_pkg::ACC_LOAD;
            state_in   = gtm_pkg::ST_SQ_SUM;
         end
         gtm_pkg::ST_SQ_SUM: begin
            cmd.acc_op = gtm_pkg::ACC_ADD;
            state_in   = gtm_pkg::ST_ROOT_GO;
         end
         gtm_pkg::ST_ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in       = gtm_pkg::ST_ROOT_WAIT;
         end
         gtm_pkg::ST_ROOT_WAIT: begin
            if (status.root_done) begin
               state_in = gtm_pkg::ST_OUTPUT;
            end
         end
         gtm_pkg::ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.clr_state = 1'b1;
               state_in      = gtm_pkg::ST_IDLE;
            end
         end
         default: state_in = gtm_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/goertzel_tone_magnitude_unit.sv
// goertzel_tone_magnitude_unit: top level, single-bin goertzel magnitude
// depends on gtm_pkg, gtm_ctrl, gtm_datapath (and gtm_isqrt below it)
//
// Usage:
//  - req_ channel: one unsigned adc word per handshake (req_valid/req_ready).
//  - rsp_ channel: one word per finished block, rsp_magnitude and
//    rsp_saturated, held in an output register until rsp_ready.
//  - csr_ channel: csr_index/csr_data writes, csr_ready is always high;
//    write only while the unit is idle.
//  - each sample is accepted in idle, then does the 40-bit state product as
//    two halves on the one shared 23x17 multiplier before the next is taken.
//  - the last sample of a block adds four more split products, two squares
//    and a 17-step bit-serial square root before the result is loaded
//    into the output register and raises rsp_valid.
//  - reset restores the default register values and clears the recursion
//    state, the sample count and the valid flag of the output register.
//  - while a finished word waits on rsp_ready, the next block's samples are
//    still taken; only a second finished block waits in its final step
//    until the output register is free.
`timescale 1ns / 1ps

module goertzel_tone_magnitude_unit #(
   parameter int SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gtm_pkg::MAG_W-1:0]       rsp_magnitude,
   output logic                            rsp_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gtm_pkg::CSR_DATA_W-1:0]  csr_data
);

   gtm_pkg::cmd_type    cmd;
   gtm_pkg::status_type status;

   assign csr_ready = 1'b1;

   gtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gtm_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_sample    (req_sample),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_magnitude (rsp_magnitude),
      .rsp_saturated (rsp_saturated)
   );

endmodule

FILE: rtl/gtm_checker.sv
// gtm_checker: port-level assertions for goertzel_tone_magnitude_unit
// bound to the top level below; depends on gtm_pkg widths
`timescale 1ns / 1ps

module gtm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gtm_pkg::MAG_W-1:0]       rsp_magnitude,
   input logic                            rsp_saturated
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_magnitude) && $stable(rsp_saturated))
      else $error("stalled result word changed");

   // saturation flag implies clipped magnitude
   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_magnitude == {gtm_pkg::MAG_W{1'b1}})
      else $error("saturated word without full-scale magnitude");

   // a sample word keeps the unit busy for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample word taken in back-to-back cycles");

endmodule

bind goertzel_tone_magnitude_unit gtm_checker u_gtm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_magnitude (rsp_magnitude),
   .rsp_saturated (rsp_saturated)
);

FILE: bench/testbench.sv
// testbench: self-checking bench for goertzel_tone_magnitude_unit, directed
// table then random blocks, checked by a bit-true goertzel magnitude predictor
// depends on gtm_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;

   localparam int SAMPLE_BITS_DEF = gtm_pkg::SAMPLE_BITS_DEF;
   localparam int CSR_IDX_W       = gtm_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W      = gtm_pkg::CSR_DATA_W;
   localparam int MAG_W           = gtm_pkg::MAG_W;
   localparam int LEN_W           = gtm_pkg::LEN_W;
   localparam int COEF_W          = gtm_pkg::COEF_W;
   localparam int STATE_W         = gtm_pkg::STATE_W;
   localparam int Q14_SHIFT       = gtm_pkg::Q14_SHIFT;
   localparam int Q16_SHIFT       = gtm_pkg::Q16_SHIFT;
   localparam int MAG_MAX         = gtm_pkg::MAG_MAX;

   localparam int  TOTAL_WORDS   = 950;
   localparam int  SETTLE_CYCLES = 80;
   localparam int  QUIET_WORDS   = 150;
   localparam time RUN_LIMIT     = 2_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  value;
      logic                   typed;
      logic [MAG_W-1:0]       mag;
      logic                   sat;
   } plan_row_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             sat;
   } tone_type;

   localparam int PLAN_ROWS = 42;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd1,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b1, 16'd102,  1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_SCALE_RECIPROCAL, 16'd0,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b1, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_SCALE_RECIPROCAL, 16'hffff, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b1, 16'd4095, 1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd0,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b1, 16'd4095, 1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd1,    1'b1, 16'd1,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd3,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd0,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  CSR_SPARE_LO,                  16'hffff, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  CSR_SPARE_HI,                  16'h0001, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_RECURSION_COEFF,  16'h7fff, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_COSINE_TERM,      16'h0000, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_SINE_TERM,        16'h4000, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd5,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_COSINE_TERM,      16'hc000, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd200,  1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd100,  1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd2000, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd3000, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd2,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_RECURSION_COEFF,  16'h8000, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_SINE_TERM,        16'hc000, 1'b0, 16'd0,    1'b0},
      '{ROW_WRITE,  gtm_pkg::CSR_BLOCK_LENGTH,     16'd3,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd0,    1'b0, 16'd0,    1'b0},
      '{ROW_SAMPLE, gtm_pkg::CSR_BLOCK_LENGTH,     16'd4095, 1'b0, 16'd0,    1'b0}
   };

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS_DEF-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [MAG_W-1:0]       rsp_magnitude;
   logic                   rsp_saturated;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_data      = '0;

   // predictor copy of the registers and the recursion state
   logic [LEN_W-1:0]         blk_len   = gtm_pkg::RST_BLOCK_LENGTH;
   logic signed [COEF_W-1:0] rec_coef  = gtm_pkg::RST_RECURSION_COEFF;
   logic signed [COEF_W-1:0] cos_coef  = gtm_pkg::RST_COSINE_TERM;
   logic signed [COEF_W-1:0] sin_coef  = gtm_pkg::RST_SINE_TERM;
   logic [COEF_W-1:0]        scale_q16 = gtm_pkg::RST_SCALE_RECIPROCAL;
   longint                   q_prev    = 0;
   longint                   q_prev2   = 0;
   int unsigned              sample_count = 0;

   tone_type tone_queue [$];

   bit idle_on    = 1'b1;
   bit dirty      = 1'b0;
   int stall_left = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int blocks_done  = 0;
   int writes_done  = 0;
   int sat_seen     = 0;
   int mismatches   = 0;

   goertzel_tone_magnitude_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_magnitude (rsp_magnitude),
      .rsp_saturated (rsp_saturated),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("timeout at %0t with %0d results outstanding", $time, tone_queue.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint wrap_state(longint v);
      return (v <<< (64 - STATE_W)) >>> (64 - STATE_W);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   // one goertzel step; returns 1 when the word closes a block
   function automatic bit step_goertzel(input logic [SAMPLE_BITS_DEF-1:0] x,
                                        output tone_type tone);
      longint      q0, re, im, are, aim;
      longint unsigned root;
      int unsigned eff_len;
      eff_len = (blk_len == 0) ? 1 : blk_len;
      q0 = round_shift(longint'(rec_coef) * q_prev, Q14_SHIFT) - q_prev2 + longint'(x);
      q_prev2 = q_prev;
      q_prev  = wrap_state(q0);
      sample_count = (sample_count + 1) & 8'hff;
      tone = '0;
      if (sample_count < eff_len && sample_count != 0) return 1'b0;
      re = q_prev - round_shift(q_prev2 * longint'(cos_coef), Q14_SHIFT);
      im = round_shift(q_prev2 * longint'(sin_coef), Q14_SHIFT);
      re = round_shift(re * longint'(scale_q16), Q16_SHIFT);
      im = round_shift(im * longint'(scale_q16), Q16_SHIFT);
      are = (re < 0) ? -re : re;
      aim = (im < 0) ? -im : im;
      if (are > MAG_MAX || aim > MAG_MAX) begin
         tone.mag = MAG_W'(MAG_MAX);
         tone.sat = 1'b1;
      end else begin
         root = root_floor(are * are + aim * aim);
         tone.sat = (root > MAG_MAX);
         tone.mag = tone.sat ? MAG_W'(MAG_MAX) : root[MAG_W-1:0];
      end
      q_prev  = 0;
      q_prev2 = 0;
      sample_count = 0;
      return 1'b1;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         gtm_pkg::CSR_BLOCK_LENGTH:     blk_len   = data[LEN_W-1:0];
         gtm_pkg::CSR_RECURSION_COEFF:  rec_coef  = data;
         gtm_pkg::CSR_COSINE_TERM:      cos_coef  = data;
         gtm_pkg::CSR_SINE_TERM:        sin_coef  = data;
         gtm_pkg::CSR_SCALE_RECIPROCAL: scale_q16 = data;
         default: ;
      endcase
   endfunction

   // wait for all blocks to drain and the datapath to go quiet
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (tone_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      dirty = 1'b0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (dirty) settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      writes_done++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_sample(logic [SAMPLE_BITS_DEF-1:0] x, logic use_typed,
                              logic [MAG_W-1:0] typed_mag, logic typed_sat);
      tone_type tone;
      int       gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (!req_ready);
      dirty = 1'b1;
      words_sent++;
      if (step_goertzel(x, tone)) begin
         blocks_done++;
         if (use_typed) tone = '{typed_mag, typed_sat};
         tone_queue.push_back(tone);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      tone_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_saturated === 1'b1) sat_seen++;
         if (tone_queue.size() == 0) begin
            $display("%0t: unexpected result word, magnitude %0d saturated %0d",
                     $time, rsp_magnitude, rsp_saturated);
            mismatches++;
         end else begin
            want = tone_queue.pop_front();
            if (rsp_magnitude !== want.mag) begin
               $display("%0t: magnitude expected %0d, got %0d",
                        $time, want.mag, rsp_magnitude);
               mismatches++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %0d, got %0d",
                        $time, want.sat, rsp_saturated);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int phase;
      int len_v, eff_len, n_words, c_v, s_v;
      logic [SAMPLE_BITS_DEF-1:0] x;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE)
            write_reg(directed_plan[i].idx, directed_plan[i].value);
         else
            send_sample(directed_plan[i].value[SAMPLE_BITS_DEF-1:0], directed_plan[i].typed,
                        directed_plan[i].mag, directed_plan[i].sat);
      end

      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         idle_on = (words_sent < TOTAL_WORDS - QUIET_WORDS) ? ($urandom_range(0, 3) != 0) : 1'b0;
         if (phase == 0) len_v = 255;
         else begin
            case ($urandom_range(0, 19))
               0:       len_v = 0;
               1:       len_v = $urandom_range(80, 255);
               2, 3, 4: len_v = $urandom_range(13, 40);
               default: len_v = $urandom_range(1, 12);
            endcase
         end
         eff_len = (len_v == 0) ? 1 : len_v;
         write_reg(gtm_pkg::CSR_BLOCK_LENGTH, 16'(len_v));
         if (phase == 0 || $urandom_range(0, 9) < 6) begin
            // coherent tone bin
            c_v = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 3) != 0) write_reg(gtm_pkg::CSR_RECURSION_COEFF, 16'(c_v));
            if ($urandom_range(0, 3) != 0) write_reg(gtm_pkg::CSR_COSINE_TERM, 16'(c_v >>> 1));
            if ($urandom_range(0, 3) != 0)
               write_reg(gtm_pkg::CSR_SINE_TERM,
                         16'(int'($urandom_range(0, 32768)) - 16384));
         end else begin
            write_reg(gtm_pkg::CSR_RECURSION_COEFF, 16'($urandom_range(0, 65535)));
            write_reg(gtm_pkg::CSR_COSINE_TERM, 16'($urandom_range(0, 65535)));
            write_reg(gtm_pkg::CSR_SINE_TERM, 16'($urandom_range(0, 65535)));
         end
         if ($urandom_range(0, 3) != 0) begin
            s_v = (131072 + eff_len / 2) / eff_len;
            if (s_v > 65535) s_v = 65535;
            if ($urandom_range(0, 1) == 0) s_v = $urandom_range(0, 65535);
            write_reg(gtm_pkg::CSR_SCALE_RECIPROCAL, 16'(s_v));
         end
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_IDX_W'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)));
         n_words = (eff_len > 40) ? eff_len : eff_len * $urandom_range(1, 3);
         // partial block leaves the count mid-way into the next setting
         if (eff_len > 1 && $urandom_range(0, 3) == 0) n_words += $urandom_range(1, eff_len - 1);
         if (n_words > TOTAL_WORDS - words_sent) n_words = TOTAL_WORDS - words_sent;
         repeat (n_words) begin
            case ($urandom_range(0, 15))
               0:       x = '0;
               1:       x = '1;
               default: x = SAMPLE_BITS_DEF'($urandom_range(0, 4095));
            endcase
            send_sample(x, 1'b0, '0, 1'b0);
         end
         phase++;
      end

      settle();
      $display("run covered %0d sample words, %0d finished blocks, %0d register writes",
               words_sent, blocks_done, writes_done);
      $display("checked %0d magnitude words, %0d of them saturated", results_seen, sat_seen);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/gtm_pkg.sv
rtl/gtm_isqrt.sv
rtl/gtm_datapath.sv
rtl/gtm_ctrl.sv
rtl/goertzel_tone_magnitude_unit.sv
rtl/gtm_checker.sv
bench/testbench.sv
